// ===== rtl/stc_pkg.sv =====
// Shared types, token codes and keyword tables for the shader token classifier.
// Used by stc_front, stc_queue, stc_back and shader_token_classifier.
package stc_pkg;

  localparam int unsigned LenBits    = 16;
  localparam int unsigned KwMaxChars = 6;
  localparam int unsigned KwBits     = 8 * KwMaxChars;
  localparam int unsigned NumKw      = 21;
  localparam int unsigned TokLenW    = 16;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [LenBits-1:0] LenMax    = {LenBits{1'b1}};
  localparam logic [TokLenW-1:0] TokLenMax = {TokLenW{1'b1}};

  localparam logic [5:0] KEof       = 6'd0;
  localparam logic [5:0] KIdent     = 6'd1;
  localparam logic [5:0] KNumber    = 6'd2;
  localparam logic [5:0] KKeyword0  = 6'd3;
  localparam logic [5:0] KPlus      = 6'd24;
  localparam logic [5:0] KMinus     = 6'd25;
  localparam logic [5:0] KStar      = 6'd26;
  localparam logic [5:0] KSlash     = 6'd27;
  localparam logic [5:0] KAssign    = 6'd28;
  localparam logic [5:0] KEqual     = 6'd29;
  localparam logic [5:0] KNotEqual  = 6'd30;
  localparam logic [5:0] KBang      = 6'd31;
  localparam logic [5:0] KLess      = 6'd32;
  localparam logic [5:0] KLessEq    = 6'd33;
  localparam logic [5:0] KGreater   = 6'd34;
  localparam logic [5:0] KGreaterEq = 6'd35;
  localparam logic [5:0] KLParen    = 6'd36;
  localparam logic [5:0] KRParen    = 6'd37;
  localparam logic [5:0] KLBracket  = 6'd38;
  localparam logic [5:0] KRBracket  = 6'd39;
  localparam logic [5:0] KLBrace    = 6'd40;
  localparam logic [5:0] KRBrace    = 6'd41;
  localparam logic [5:0] KComma     = 6'd42;
  localparam logic [5:0] KSemi      = 6'd43;
  localparam logic [5:0] KDot       = 6'd44;
  localparam logic [5:0] KUnknown   = 6'd45;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    logic [7:0]         char_code;
    logic [TokLenW-1:0] token_length;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic [7:0]         code;
    logic [TokLenW-1:0] len;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } tok_pair_t;

  // Keyword text with the first character in the low byte (strings written reversed).
  function automatic logic [63:0] kw_text(int unsigned k);
    logic [63:0] t;
    case (k)
      0:       t = 64'("fi");
      1:       t = 64'("esle");
      2:       t = 64'("2cev");
      3:       t = 64'("3cev");
      4:       t = 64'("4cev");
      5:       t = 64'("2tam");
      6:       t = 64'("3tam");
      7:       t = 64'("4tam");
      8:       t = 64'("3x2tam");
      9:       t = 64'("4x2tam");
      10:      t = 64'("2x3tam");
      11:      t = 64'("4x3tam");
      12:      t = 64'("2x4tam");
      13:      t = 64'("3x4tam");
      14:      t = 64'("elbuod");
      15:      t = 64'("taolf");
      16:      t = 64'("tni");
      17:      t = 64'("tniu");
      18:      t = 64'("loob");
      19:      t = 64'("eurt");
      20:      t = 64'("eslaf");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(int unsigned k);
    logic [3:0] n;
    case (k)
      0:                       n = 4'd2;
      8, 9, 10, 11, 12, 13, 14: n = 4'd6;
      15, 20:                  n = 4'd5;
      16:                      n = 4'd3;
      default:                 n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [TokLenW-1:0] sat_len(logic [LenBits-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return (w > 32'(TokLenMax)) ? TokLenMax : w[TokLenW-1:0];
  endfunction

endpackage

// ===== rtl/stc_front.sv =====
// Lexer front end: holds the tokenizer state and classifies one byte per cycle while accept_i is high.
// Produces up to two finished tokens per item. Depends on stc_pkg.
module stc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  stc_pkg::in_item_t  item_i,
  output logic               enq_o,
  output stc_pkg::tok_pair_t pair_o
);

  typedef enum logic [3:0] {
    ModeStart   = 4'd0,
    ModeIdent   = 4'd1,
    ModeNumber  = 4'd2,
    ModeDot     = 4'd3,
    ModeEq      = 4'd4,
    ModeBang    = 4'd5,
    ModeLt      = 4'd6,
    ModeGt      = 4'd7,
    ModeComment = 4'd8
  } mode_e;

  localparam logic [7:0] ChHash  = "#";
  localparam logic [7:0] ChUnder = "_";
  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChEq    = "=";
  localparam logic [7:0] ChBang  = "!";
  localparam logic [7:0] ChLt    = "<";
  localparam logic [7:0] ChGt    = ">";
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChMinus = "-";
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChLPar  = "(";
  localparam logic [7:0] ChRPar  = ")";
  localparam logic [7:0] ChLBrk  = "[";
  localparam logic [7:0] ChRBrk  = "]";
  localparam logic [7:0] ChLBrc  = "{";
  localparam logic [7:0] ChRBrc  = "}";
  localparam logic [7:0] ChComma = ",";
  localparam logic [7:0] ChSemi  = ";";
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;

  localparam logic [stc_pkg::TokLenW-1:0] Len1 = stc_pkg::TokLenW'(1);
  localparam logic [stc_pkg::TokLenW-1:0] Len2 = stc_pkg::TokLenW'(2);

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_id_start(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == ChUnder);
  endfunction

  function automatic stc_pkg::tok_t mk_tok(logic [5:0] kind, logic [7:0] code,
                                          logic [stc_pkg::TokLenW-1:0] len);
    stc_pkg::tok_t t;
    t.kind = kind;
    t.code = code;
    t.len  = len;
    return t;
  endfunction

  mode_e                            mode_q, mode_d;
  logic [stc_pkg::KwBits-1:0]       prefix_q, prefix_d;
  logic [stc_pkg::LenBits-1:0]      len_q, len_d;
  logic                             dot_q, dot_d;

  logic [7:0]                       c;
  logic [stc_pkg::LenBits-1:0]      len_inc;
  logic [5:0]                       id_kind;
  logic                             fv, sv, v0, v1;
  stc_pkg::tok_t                    ft, st, t0, t1;
  mode_e                            s_mode;
  logic [stc_pkg::KwBits-1:0]       s_prefix;
  logic [stc_pkg::LenBits-1:0]      s_len;
  logic [5:0]                       pair_kind;

  assign c       = item_i.ch;
  assign len_inc = (len_q == stc_pkg::LenMax) ? len_q : len_q + stc_pkg::LenBits'(1);

  always_comb begin
    logic [63:0] kt;
    logic [3:0]  kl;
    id_kind = stc_pkg::KIdent;
    for (int k = stc_pkg::NumKw - 1; k >= 0; k--) begin
      kt = stc_pkg::kw_text(k);
      kl = stc_pkg::kw_len(k);
      if ((32'(kl) <= stc_pkg::KwMaxChars) && (32'(len_q) == 32'(kl)) &&
          (prefix_q == kt[stc_pkg::KwBits-1:0])) begin
        id_kind = stc_pkg::KKeyword0 + 6'(k);
      end
    end
  end

  // Pending token that a terminating byte or end of input finishes.
  always_comb begin
    fv = 1'b1;
    ft = mk_tok(stc_pkg::KEof, 8'd0, '0);
    case (mode_q)
      ModeIdent:  ft = mk_tok(id_kind, 8'd0, stc_pkg::sat_len(len_q));
      ModeNumber: ft = mk_tok(stc_pkg::KNumber, 8'd0, stc_pkg::sat_len(len_q));
      ModeDot:    ft = mk_tok(stc_pkg::KDot, 8'd0, Len1);
      ModeEq:     ft = mk_tok(stc_pkg::KAssign, 8'd0, Len1);
      ModeBang:   ft = mk_tok(stc_pkg::KBang, ChBang, Len1);
      ModeLt:     ft = mk_tok(stc_pkg::KLess, 8'd0, Len1);
      ModeGt:     ft = mk_tok(stc_pkg::KGreater, 8'd0, Len1);
      default:    fv = 1'b0;
    endcase
  end

  // Token start from a cleared state.
  always_comb begin
    sv       = 1'b1;
    st       = mk_tok(stc_pkg::KUnknown, c, Len1);
    s_mode   = ModeStart;
    s_prefix = '0;
    s_len    = '0;
    if (is_space(c)) begin
      sv = 1'b0;
    end else if (is_id_start(c)) begin
      sv       = 1'b0;
      s_mode   = ModeIdent;
      s_prefix = stc_pkg::KwBits'(c);
      s_len    = stc_pkg::LenBits'(1);
    end else if (is_digit(c)) begin
      sv     = 1'b0;
      s_mode = ModeNumber;
      s_len  = stc_pkg::LenBits'(1);
    end else begin
      case (c)
        ChDot:   begin sv = 1'b0; s_mode = ModeDot;     end
        ChHash:  begin sv = 1'b0; s_mode = ModeComment; end
        ChEq:    begin sv = 1'b0; s_mode = ModeEq;      end
        ChBang:  begin sv = 1'b0; s_mode = ModeBang;    end
        ChLt:    begin sv = 1'b0; s_mode = ModeLt;      end
        ChGt:    begin sv = 1'b0; s_mode = ModeGt;      end
        ChPlus:  st = mk_tok(stc_pkg::KPlus, 8'd0, Len1);
        ChMinus: st = mk_tok(stc_pkg::KMinus, 8'd0, Len1);
        ChStar:  st = mk_tok(stc_pkg::KStar, 8'd0, Len1);
        ChSlash: st = mk_tok(stc_pkg::KSlash, 8'd0, Len1);
        ChLPar:  st = mk_tok(stc_pkg::KLParen, 8'd0, Len1);
        ChRPar:  st = mk_tok(stc_pkg::KRParen, 8'd0, Len1);
        ChLBrk:  st = mk_tok(stc_pkg::KLBracket, 8'd0, Len1);
        ChRBrk:  st = mk_tok(stc_pkg::KRBracket, 8'd0, Len1);
        ChLBrc:  st = mk_tok(stc_pkg::KLBrace, 8'd0, Len1);
        ChRBrc:  st = mk_tok(stc_pkg::KRBrace, 8'd0, Len1);
        ChComma: st = mk_tok(stc_pkg::KComma, 8'd0, Len1);
        ChSemi:  st = mk_tok(stc_pkg::KSemi, 8'd0, Len1);
        default: st = mk_tok(stc_pkg::KUnknown, c, Len1);
      endcase
    end
  end

  always_comb begin
    case (mode_q)
      ModeEq:   pair_kind = stc_pkg::KEqual;
      ModeBang: pair_kind = stc_pkg::KNotEqual;
      ModeLt:   pair_kind = stc_pkg::KLessEq;
      default:  pair_kind = stc_pkg::KGreaterEq;
    endcase
  end

  always_comb begin
    logic finish;
    mode_d   = mode_q;
    prefix_d = prefix_q;
    len_d    = len_q;
    dot_d    = dot_q;
    v0       = 1'b0;
    t0       = ft;
    v1       = 1'b0;
    t1       = st;
    finish   = 1'b0;
    if (item_i.end_of_input) begin
      v0       = fv;
      v1       = 1'b1;
      t1       = mk_tok(stc_pkg::KEof, 8'd0, '0);
      mode_d   = ModeStart;
      prefix_d = '0;
      len_d    = '0;
      dot_d    = 1'b0;
    end else begin
      case (mode_q)
        ModeIdent: begin
          if (is_id_start(c) || is_digit(c)) begin
            for (int i = 0; i < stc_pkg::KwMaxChars; i++) begin
              if (32'(len_q) == i) prefix_d[8*i +: 8] = c;
            end
            len_d = len_inc;
          end else begin
            finish = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(c)) begin
            len_d = len_inc;
          end else if (c == ChDot && !dot_q) begin
            dot_d = 1'b1;
            len_d = len_inc;
          end else begin
            finish = 1'b1;
          end
        end
        ModeDot: begin
          if (is_digit(c)) begin
            mode_d = ModeNumber;
            len_d  = stc_pkg::LenBits'(2);
            dot_d  = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
        ModeEq, ModeBang, ModeLt, ModeGt: begin
          if (c == ChEq) begin
            v0     = 1'b1;
            t0     = mk_tok(pair_kind, 8'd0, Len2);
            mode_d = ModeStart;
          end else begin
            finish = 1'b1;
          end
        end
        ModeComment: begin
          if (c == ChLf || c == ChCr) mode_d = ModeStart;
        end
        default: finish = 1'b1;
      endcase
      if (finish) begin
        v0       = fv;
        v1       = sv;
        mode_d   = s_mode;
        prefix_d = s_prefix;
        len_d    = s_len;
        dot_d    = 1'b0;
      end
    end
  end

  assign enq_o       = accept_i && (v0 || v1);
  assign pair_o.two  = v0 && v1;
  assign pair_o.tok0 = v0 ? t0 : t1;
  assign pair_o.tok1 = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeStart;
      prefix_q <= '0;
      len_q    <= '0;
      dot_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      prefix_q <= prefix_d;
      len_q    <= len_d;
      dot_q    <= dot_d;
    end
  end

`ifndef SYNTH
  a_len_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeStart || mode_q == ModeComment) |-> (len_q == '0 && !dot_q))
    else $error("length or dot flag left set between tokens");
  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.end_of_input) |=> (mode_q == ModeStart && prefix_q == '0))
    else $error("end of input did not return lexer to start");
  a_two_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_o.two && accept_i) |-> enq_o)
    else $error("two-token item not enqueued");
`endif

endmodule

// ===== rtl/stc_queue.sv =====
// Short queue of token pairs between the lexer front end and the result stage.
// Depends on stc_pkg.
module stc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enq_i,
  input  stc_pkg::tok_pair_t enq_data_i,
  input  logic               deq_i,
  output logic               full_o,
  output logic               empty_o,
  output stc_pkg::tok_pair_t head_o
);

  stc_pkg::tok_pair_t              mem_q [stc_pkg::QDepth];
  logic [stc_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [stc_pkg::QCntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == stc_pkg::QCntW'(stc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (enq_i) mem_q[wr_q] <= enq_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (enq_i) wr_q <= wr_q + stc_pkg::QPtrW'(1);
      if (deq_i) rd_q <= rd_q + stc_pkg::QPtrW'(1);
      case ({enq_i, deq_i})
        2'b10:   cnt_q <= cnt_q + stc_pkg::QCntW'(1);
        2'b01:   cnt_q <= cnt_q - stc_pkg::QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stc_pkg::QCntW'(stc_pkg::QDepth))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_i |-> !full_o)
    else $error("enqueue into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> !empty_o)
    else $error("dequeue from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq_i && !deq_i) |=> cnt_q == $past(cnt_q) + stc_pkg::QCntW'(1))
    else $error("queue count did not advance");
`endif

endmodule

// ===== rtl/stc_back.sv =====
// Result stage: splits each queued token pair into single result items.
// Depends on stc_pkg.
module stc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  stc_pkg::tok_pair_t head_i,
  output logic               deq_o,
  output logic               empty_o,
  input  logic               pop_i,
  output stc_pkg::result_t   result_o
);

  logic          second_q;
  logic          last;
  stc_pkg::tok_t tok;

  assign tok     = second_q ? head_i.tok1 : head_i.tok0;
  assign last    = second_q || !head_i.two;
  assign empty_o = q_empty_i;
  assign deq_o   = pop_i && !q_empty_i && last;

  assign result_o.token_kind   = tok.kind;
  assign result_o.char_code    = tok.code;
  assign result_o.token_length = tok.len;
  assign result_o.last         = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (pop_i && !q_empty_i) begin
      second_q <= !last;
    end
  end

`ifndef SYNTH
  a_second_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (!q_empty_i && head_i.two))
    else $error("second result selected without a pair");
  a_second_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (second_q && !pop_i) |=> second_q)
    else $error("second result dropped without pop");
  a_second_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (second_q && pop_i) |-> deq_o)
    else $error("pair not retired after second result");
`endif

endmodule

// ===== rtl/shader_token_classifier.sv =====
// Top level of the shader token classifier: lexer front end, pair queue and
// result stage. Depends on stc_pkg, stc_front, stc_queue and stc_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | push_i / full_o    | item_i   (ch, end_of_input)
//   result   | empty_o / pop_i    | result_o (token_kind, char_code,
//            |                    |           token_length, last)
//
// One byte is classified per cycle while full_o is low; its tokens (zero,
// one or two) are written into a four-entry pair queue at the accepting
// edge and can be popped from the next edge on.
// Results leave one per cycle while not empty; two tokens need two pops.
// full_o rises only when the pair queue holds four entries.
// Reset clears the lexer to between-tokens and empties the queue.
module shader_token_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  stc_pkg::in_item_t item_i,
  output logic              empty_o,
  input  logic              pop_i,
  output stc_pkg::result_t  result_o
);

  logic               accept;
  logic               enq;
  logic               deq;
  logic               q_empty;
  stc_pkg::tok_pair_t enq_pair;
  stc_pkg::tok_pair_t head;

  assign accept = push_i && !full_o;

  stc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .enq_o    (enq),
    .pair_o   (enq_pair)
  );

  stc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_data_i (enq_pair),
    .deq_i      (deq),
    .full_o     (full_o),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  stc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .head_i    (head),
    .deq_o     (deq),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .result_o  (result_o)
  );

endmodule
